FILE: hdl/bsearch_pkg.sv
package bsearch_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = 10;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 5;
    localparam int BOUND_W     = IDX_W + 2;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 16;
    localparam int STEP_W      = 2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 2'd0;
    localparam step_t STEP_PROBE = 2'd1;
    localparam step_t STEP_TEST  = 2'd2;
    localparam step_t STEP_EMIT  = 2'd3;

    typedef enum logic [1:0] {
        COND_SEARCH,
        COND_EMPTY,
        COND_MATCH,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic  accept;
        logic  probe;
        logic  test;
        logic  emit;
        cond_t cond;
        step_t jump;
        step_t seq;
    } ucode_t;

    function automatic ucode_t ucode_rom(step_t step);
        ucode_t uw;
        uw = '{accept: 1'b0, probe: 1'b0, test: 1'b0, emit: 1'b0,
               cond: COND_SEARCH, jump: STEP_IDLE, seq: STEP_IDLE};
        case (step)
            STEP_IDLE:
            begin
                uw.accept = 1'b1;
                uw.cond   = COND_SEARCH;
                uw.jump   = STEP_PROBE;
                uw.seq    = STEP_IDLE;
            end
            STEP_PROBE:
            begin
                uw.probe = 1'b1;
                uw.cond  = COND_EMPTY;
                uw.jump  = STEP_EMIT;
                uw.seq   = STEP_TEST;
            end
            STEP_TEST:
            begin
                uw.test = 1'b1;
                uw.cond = COND_MATCH;
                uw.jump = STEP_EMIT;
                uw.seq  = STEP_PROBE;
            end
            STEP_EMIT:
            begin
                uw.emit = 1'b1;
                uw.cond = COND_OUT_FREE;
                uw.jump = STEP_IDLE;
                uw.seq  = STEP_EMIT;
            end
            default:
            begin
                uw.cond = COND_SEARCH;
                uw.jump = STEP_IDLE;
                uw.seq  = STEP_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

FILE: hdl/sorted_array_binary_search.sv
// Binary search over a 1024-entry store of signed 32-bit elements. A load item
// (tuser = 0) writes value at load_index and returns nothing. A search item
// (tuser = 1) probes the floor midpoint of [low_bound, high_bound] and returns
// one item: found in tuser, position and comparison count in tdata. Each probe
// is one synchronous store read (the PROBE step) followed by one compare (the
// TEST step). Control runs from a four-word microcode table; the input is held
// off while a search is in progress, and a finished result waits in the output
// register while the next item enters.
module sorted_array_binary_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // load_index[9:0], value[41:10], low_bound[51:42], high_bound[61:52], zero
    input  logic [bsearch_pkg::S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // position[9:0], comparisons[14:10], zero
    output logic [bsearch_pkg::M_TDATA_W-1:0] m_tdata,
    // found
    output logic                              m_tuser
);

    localparam int IW = bsearch_pkg::IDX_W;
    localparam int DW = bsearch_pkg::DATA_W;
    localparam int CW = bsearch_pkg::CNT_W;
    localparam int BW = bsearch_pkg::BOUND_W;
    localparam int AW = bsearch_pkg::ADDR_W;

    logic [DW-1:0] store_mem [bsearch_pkg::STORE_DEPTH];

    bsearch_pkg::step_t  step_reg, step_next;
    bsearch_pkg::ucode_t uw;

    logic [IW-1:0] load_index, low_bound, high_bound;
    logic [DW-1:0] value;

    logic signed [BW-1:0] lo_reg, hi_reg;
    logic signed [BW:0]   bound_sum;
    logic [IW-1:0]        mid;
    logic [IW-1:0]        mid_reg;
    logic [DW-1:0]        key_reg;
    logic [DW-1:0]        rd_data_reg;
    logic                 probe_ok_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 found_reg;
    logic [IW-1:0]        pos_reg;

    logic                 m_tvalid_reg;
    logic                 m_found_reg;
    logic [IW-1:0]        m_pos_reg;
    logic [CW-1:0]        m_cnt_reg;

    logic          in_accept, is_search, range_empty, match, greater, out_free, cond_hit;
    logic [DW-1:0] elem;

    assign uw = bsearch_pkg::ucode_rom(step_reg);

    assign load_index = s_tdata[IW-1:0];
    assign value      = s_tdata[IW+DW-1:IW];
    assign low_bound  = s_tdata[2*IW+DW-1:IW+DW];
    assign high_bound = s_tdata[3*IW+DW-1:2*IW+DW];

    assign s_tready  = uw.accept;
    assign in_accept = s_tvalid & s_tready;
    assign is_search = (s_tuser == bsearch_pkg::OP_SEARCH);

    assign range_empty = lo_reg > hi_reg;
    assign bound_sum   = (BW+1)'(lo_reg) + (BW+1)'(hi_reg);
    assign mid         = bound_sum[IW:1];

    assign elem     = probe_ok_reg ? rd_data_reg : '0;
    assign match    = (elem == key_reg);
    assign greater  = $signed(elem) > $signed(key_reg);
    assign out_free = ~m_tvalid_reg | m_tready;

    always_comb
    begin
        case (uw.cond)
            bsearch_pkg::COND_SEARCH:   cond_hit = in_accept & is_search;
            bsearch_pkg::COND_EMPTY:    cond_hit = range_empty;
            bsearch_pkg::COND_MATCH:    cond_hit = match;
            bsearch_pkg::COND_OUT_FREE: cond_hit = out_free;
            default:                    cond_hit = 1'b0;
        endcase
        step_next = cond_hit ? uw.jump : uw.seq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= bsearch_pkg::STEP_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (uw.emit && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && !is_search && (int'(load_index) < bsearch_pkg::STORE_DEPTH))
        begin
            store_mem[AW'(load_index)] <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uw.probe)
        begin
            rd_data_reg <= store_mem[AW'(mid)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && is_search)
        begin
            lo_reg    <= BW'(low_bound);
            hi_reg    <= BW'(high_bound);
            key_reg   <= value;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        if (uw.probe && !range_empty)
        begin
            mid_reg      <= mid;
            probe_ok_reg <= int'(mid) < bsearch_pkg::STORE_DEPTH;
        end
        if (uw.test)
        begin
            if (match)
            begin
                cnt_reg   <= cnt_reg + CW'(1);
                found_reg <= 1'b1;
                pos_reg   <= mid_reg;
            end
            else
            begin
                cnt_reg <= cnt_reg + CW'(2);
                if (greater)
                begin
                    hi_reg <= BW'(mid_reg) - BW'(1);
                end
                else
                begin
                    lo_reg <= BW'(mid_reg) + BW'(1);
                end
            end
        end
        if (uw.emit && out_free)
        begin
            m_found_reg <= found_reg;
            m_pos_reg   <= pos_reg;
            m_cnt_reg   <= cnt_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = bsearch_pkg::M_TDATA_W'({m_cnt_reg, m_pos_reg});

endmodule

FILE: hdl/bsearch_chk.sv
module bsearch_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[9:0] == 10'd0)
        else $error("miss item with nonzero position");

    a_count_parity: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[10] == m_tuser)
        else $error("comparison count parity disagrees with found");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[14:10] <= 5'd22)
        else $error("comparison count beyond limit");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input open right after a search item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

endmodule

bind sorted_array_binary_search bsearch_chk u_bsearch_chk (.*);
